// ===== src/chained_hash_map_unit_assert.svh =====
// Assertion macros shared by the hash map RTL.
`ifndef CHAINED_HASH_MAP_UNIT_ASSERT_SVH
`define CHAINED_HASH_MAP_UNIT_ASSERT_SVH

// Implication in the same cycle, checked outside reset.
`define CHM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication in the next cycle, checked outside reset.
`define CHM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/chm_pkg.sv =====
package chm_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_FIND   = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [2:0] ST_INS_EMPTY = 3'd0;
  localparam logic [2:0] ST_INS_OCC   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_MISS      = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  localparam logic [8:0]  BUCKET_COUNT_RST = 9'd251;
  localparam logic [31:0] MIX_MUL1 = 32'h7feb352d;
  localparam logic [31:0] MIX_MUL2 = 32'h846ca68b;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] key;
    logic [31:0]        value;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_value;
    logic [8:0]  entry_count;
  } out_t;

endpackage

// ===== src/chm_hash.sv =====
module chm_hash #(
  parameter int MAX_BUCKETS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [31:0]                    key_i,
  input  logic [8:0]                     bucket_count_i,
  output logic                           done_o,
  output logic [$clog2(MAX_BUCKETS)-1:0] bucket_o
);

  localparam int BW = $clog2(MAX_BUCKETS);
  localparam int NW = $clog2(MAX_BUCKETS + 1);

  localparam logic [1:0] H_IDLE = 2'd0;
  localparam logic [1:0] H_MUL1 = 2'd1;
  localparam logic [1:0] H_MUL2 = 2'd2;
  localparam logic [1:0] H_DIV  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [31:0]   x_q, x_d;
  logic [NW-1:0] rem_q, rem_d;
  logic [NW-1:0] n_q, n_d;
  logic [4:0]    step_q, step_d;
  logic          done_q, done_d;

  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;
  logic [31:0]   cfg_w;
  logic [NW-1:0] n_eff;
  logic [NW:0]   trial;
  logic          ge;

  // The single multiplier serves both mixing rounds.
  assign mul_a = (state_q == H_MUL1) ? x_q : (x_q ^ (x_q >> 15));
  assign mul_b = (state_q == H_MUL1) ? chm_pkg::MIX_MUL1 : chm_pkg::MIX_MUL2;
  assign prod  = mul_a * mul_b;

  assign cfg_w = 32'(bucket_count_i);
  always_comb begin
    if (cfg_w == 32'd0) begin
      n_eff = NW'(1);
    end else if (cfg_w > 32'(MAX_BUCKETS)) begin
      n_eff = NW'(MAX_BUCKETS);
    end else begin
      n_eff = NW'(cfg_w);
    end
  end

  // One restoring division step per cycle, most significant bit first.
  assign trial = {rem_q, x_q[31]};
  assign ge    = trial >= {1'b0, n_q};

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    rem_d   = rem_q;
    n_d     = n_q;
    step_d  = step_q;
    done_d  = 1'b0;
    case (state_q)
      H_IDLE: begin
        if (start_i) begin
          x_d     = key_i ^ (key_i >> 16);
          n_d     = n_eff;
          rem_d   = '0;
          step_d  = '0;
          state_d = H_MUL1;
        end
      end
      H_MUL1: begin
        x_d     = prod[31:0];
        state_d = H_MUL2;
      end
      H_MUL2: begin
        x_d     = prod[31:0] ^ (prod[31:0] >> 16);
        state_d = H_DIV;
      end
      H_DIV: begin
        rem_d  = ge ? NW'(trial - {1'b0, n_q}) : NW'(trial);
        x_d    = {x_q[30:0], 1'b0};
        step_d = step_q + 5'd1;
        if (step_q == 5'd31) begin
          done_d  = 1'b1;
          state_d = H_IDLE;
        end
      end
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    n_q    <= n_d;
    step_q <= step_d;
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q[BW-1:0];

endmodule

// ===== src/chained_hash_map_unit.sv =====
// Find and remove hash the key, then walk the bucket chain until a key matches or it ends.
// Insert scans the slot flags for a free slot, hashes the key and links the entry at the head
// of its bucket; a full pool answers ST_FULL without hashing. The shared multiplier and bit
// serial modulo form the hash. One item is in work at a time; a result waits in an output register.
// After reset a clearing pass empties the bucket heads and the slot flags; no item is taken
// meanwhile. bucket_count resets to 251.
module chained_hash_map_unit #(
  parameter int MAX_BUCKETS  = 256,
  parameter int POOL_ENTRIES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  chm_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output chm_pkg::out_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int BW    = $clog2(MAX_BUCKETS);
  localparam int AW    = $clog2(POOL_ENTRIES);
  localparam int LW    = AW + 1;
  localparam int CW    = $clog2(POOL_ENTRIES + 1);
  localparam int SWEEP = (MAX_BUCKETS > POOL_ENTRIES) ? MAX_BUCKETS : POOL_ENTRIES;
  localparam int SW    = $clog2(SWEEP + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_HASH     = 4'd3;
  localparam logic [3:0] S_HEAD     = 4'd4;
  localparam logic [3:0] S_HEAD_CHK = 4'd5;
  localparam logic [3:0] S_WALK     = 4'd6;
  localparam logic [3:0] S_WALK_CHK = 4'd7;
  localparam logic [3:0] S_RESP     = 4'd8;

  // Storage.
  logic [LW-1:0] head_mem [MAX_BUCKETS];
  logic [31:0]   key_mem  [POOL_ENTRIES];
  logic [31:0]   val_mem  [POOL_ENTRIES];
  logic [LW-1:0] next_mem [POOL_ENTRIES];
  logic          used_mem [POOL_ENTRIES];

  logic [3:0]    state_q, state_d;
  logic [SW-1:0] sweep_q, sweep_d;
  logic [1:0]    cmd_q, cmd_d;
  logic [31:0]   key_q, key_d;
  logic [31:0]   val_q, val_d;
  logic [LW-1:0] ptr_q, ptr_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [BW-1:0] bkt_q, bkt_d;
  logic [LW-1:0] cur_q, cur_d;
  logic [LW-1:0] prev_q, prev_d;
  logic [LW-1:0] steps_q, steps_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0]    status_q, status_d;
  logic [31:0]   rval_q, rval_d;
  logic [8:0]    bcount_q;
  logic          out_valid_q, out_valid_d;
  chm_pkg::out_t out_data_q, out_data_d;

  logic [LW-1:0] head_rd_q, next_rd_q;
  logic [31:0]   key_rd_q, val_rd_q;
  logic          used_rd_q;

  logic          head_we, used_we, next_we, slot_we;
  logic [BW-1:0] head_waddr;
  logic [LW-1:0] head_wdata;
  logic [AW-1:0] used_waddr, next_waddr;
  logic          used_wdata;
  logic [LW-1:0] next_wdata;

  logic          hash_start, hash_done;
  logic [BW-1:0] hash_bucket;
  logic          in_xfer, cfg_wr;

  chm_hash #(
    .MAX_BUCKETS(MAX_BUCKETS)
  ) u_hash (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (hash_start),
    .key_i         (key_q),
    .bucket_count_i(bcount_q),
    .done_o        (hash_done),
    .bucket_o      (hash_bucket)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(bcount_q);

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    val_d       = val_q;
    ptr_d       = ptr_q;
    pend_d      = 1'b0;
    slot_d      = slot_q;
    bkt_d       = bkt_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    steps_d     = steps_q;
    cnt_d       = cnt_q;
    status_d    = status_q;
    rval_d      = rval_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    hash_start  = 1'b0;
    head_we     = 1'b0;
    head_waddr  = bkt_q;
    head_wdata  = NIL;
    used_we     = 1'b0;
    used_waddr  = slot_q;
    used_wdata  = 1'b0;
    next_we     = 1'b0;
    next_waddr  = slot_q;
    next_wdata  = head_rd_q;
    slot_we     = 1'b0;

    case (state_q)
      S_CLEAR: begin
        head_we    = (32'(sweep_q) < 32'(MAX_BUCKETS));
        head_waddr = BW'(sweep_q);
        used_we    = (32'(sweep_q) < 32'(POOL_ENTRIES));
        used_waddr = AW'(sweep_q);
        sweep_d    = sweep_q + SW'(1);
        if (32'(sweep_q) == 32'(SWEEP - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          cmd_d   = in_data_i.command;
          key_d   = in_data_i.key;
          val_d   = in_data_i.value;
          rval_d  = '0;
          ptr_d   = '0;
          steps_d = '0;
          prev_d  = NIL;
          case (in_data_i.command)
            chm_pkg::CMD_INSERT: state_d = S_SCAN;
            chm_pkg::CMD_FIND, chm_pkg::CMD_REMOVE: state_d = S_HASH;
            default: begin
              status_d = chm_pkg::ST_MISS;
              state_d  = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Reads of the slot flags are pipelined: the flag seen now belongs to ptr_q - 1.
        if (pend_q && !used_rd_q) begin
          slot_d  = AW'(ptr_q - LW'(1));
          state_d = S_HASH;
        end else if (!pend_q && ptr_q == NIL) begin
          status_d = chm_pkg::ST_FULL;
          state_d  = S_RESP;
        end else if (ptr_q != NIL) begin
          pend_d = 1'b1;
          ptr_d  = ptr_q + LW'(1);
        end
      end
      S_HASH: begin
        hash_start = !pend_q;
        pend_d     = 1'b1;
        if (hash_done) begin
          bkt_d   = hash_bucket;
          pend_d  = 1'b0;
          state_d = S_HEAD;
        end
      end
      S_HEAD: state_d = S_HEAD_CHK;
      S_HEAD_CHK: begin
        if (cmd_q == chm_pkg::CMD_INSERT) begin
          slot_we    = 1'b1;
          next_we    = 1'b1;
          used_we    = 1'b1;
          used_wdata = 1'b1;
          head_we    = 1'b1;
          head_wdata = LW'(slot_q);
          cnt_d      = cnt_q + CW'(1);
          status_d   = (head_rd_q == NIL) ? chm_pkg::ST_INS_EMPTY : chm_pkg::ST_INS_OCC;
          state_d    = S_RESP;
        end else begin
          cur_d   = head_rd_q;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (cur_q >= NIL || steps_q == NIL) begin
          status_d = chm_pkg::ST_MISS;
          state_d  = S_RESP;
        end else begin
          state_d = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        if (key_rd_q == key_q) begin
          rval_d = val_rd_q;
          if (cmd_q == chm_pkg::CMD_FIND) begin
            status_d = chm_pkg::ST_FOUND;
          end else begin
            status_d = chm_pkg::ST_REMOVED;
            if (prev_q == NIL) begin
              head_we    = 1'b1;
              head_wdata = next_rd_q;
            end else begin
              next_we    = 1'b1;
              next_waddr = AW'(prev_q);
              next_wdata = next_rd_q;
            end
            used_we    = 1'b1;
            used_waddr = AW'(cur_q);
            used_wdata = 1'b0;
            if (cnt_q != '0) begin
              cnt_d = cnt_q - CW'(1);
            end
          end
          state_d = S_RESP;
        end else begin
          prev_d  = cur_q;
          cur_d   = next_rd_q;
          steps_d = steps_q + LW'(1);
          state_d = S_WALK;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d             = 1'b1;
          out_data_d.status       = status_q;
          out_data_d.result_value = rval_q;
          out_data_d.entry_count  = 9'(cnt_q);
          state_d                 = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      sweep_q     <= '0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      bcount_q    <= chm_pkg::BUCKET_COUNT_RST;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        bcount_q <= pwdata[8:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    val_q      <= val_d;
    ptr_q      <= ptr_d;
    slot_q     <= slot_d;
    bkt_q      <= bkt_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    steps_q    <= steps_d;
    status_q   <= status_d;
    rval_q     <= rval_d;
    out_data_q <= out_data_d;
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rd_q <= head_mem[bkt_q];
  end

  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[used_waddr] <= used_wdata;
    end
    used_rd_q <= used_mem[ptr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_rd_q <= next_mem[cur_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      key_mem[slot_q] <= key_q;
      val_mem[slot_q] <= val_q;
    end
    key_rd_q <= key_mem[cur_q[AW-1:0]];
    val_rd_q <= val_mem[cur_q[AW-1:0]];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`include "chained_hash_map_unit_assert.svh"

  `CHM_ASSERT_NOW(a_count_bound, 1'b1, 32'(cnt_q) <= 32'(POOL_ENTRIES))
  `CHM_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !in_ready_o)
  `CHM_ASSERT_NOW(a_hash_done_waited, hash_done, state_q == S_HASH)

endmodule
